[sv/ctpf_pkg.sv]
// Package with the shared types and constants of the corner triangle fill block.
package ctpf_pkg;

  localparam int MaxWidth    = 256;
  localparam int MaxHeight   = 256;
  localparam int XW          = $clog2(MaxWidth);
  localparam int YW          = $clog2(MaxHeight);
  localparam int AddrW       = XW + YW;
  localparam int Depth       = 1 << AddrW;
  localparam int PixW        = 32;
  localparam int DimW        = 9;
  localparam int LegW        = 8;
  localparam int CornerExtra = 5;
  localparam int SW          = 12;
  localparam int PW          = 2 * SW;
  localparam int NW          = SW + PW;
  localparam int MagW        = NW - 1;
  localparam int DenW        = 18;
  localparam int QW          = 11;
  localparam int PaddrW      = 4;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_CLEN    = 2'd2,
    REG_CHEIGHT = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    CORNER_UL = 2'd0,
    CORNER_UR = 2'd1,
    CORNER_LL = 2'd2,
    CORNER_LR = 2'd3
  } corner_e;

  // Image geometry seen by the pipeline
  typedef struct packed {
    logic [DimW-1:0] w;
    logic [DimW-1:0] v;
    logic [DimW-1:0] l;
    logic [DimW-1:0] h;
  } ctpf_cfg_t;

  // Per-item sideband carried along the pipeline
  typedef struct packed {
    cmd_e            cmd;
    logic [XW-1:0]   x;
    logic [YW-1:0]   y;
    logic [PixW-1:0] pix;
    logic [DimW-1:0] w;
    logic [DimW-1:0] v;
    logic            oob;
    logic            in_corner;
    logic            ceil_x;
    logic            ceil_y;
  } ctpf_meta_t;

endpackage

[sv/ctpf_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module ctpf_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ctpf_geom.sv]
// Corner membership and projection numerators, four pipeline stages.
module ctpf_geom import ctpf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ctpf_meta_t       meta_i,
  input  ctpf_cfg_t        cfg_i,
  output logic             valid_o,
  output ctpf_meta_t       meta_o,
  output logic             neg_x_o,
  output logic             neg_y_o,
  output logic [MagW-1:0]  mag_x_o,
  output logic [MagW-1:0]  mag_y_o,
  output logic [DenW-1:0]  den_o
);

  // Stage A: captured item
  logic                 a_v_q;
  ctpf_meta_t           a_meta_q;
  ctpf_meta_t           a_meta_in;
  logic [DimW-1:0]      a_l_q, a_h_q;
  logic signed [SW-1:0] xs, ys, ws, vs, ls, hs;
  ctpf_meta_t           a_meta_d;

  // Stage B: products
  logic                 b_v_q;
  ctpf_meta_t           b_meta_q;
  logic signed [SW-1:0] b_l_q, b_h_q;
  logic signed [PW-1:0] b_yl_q, b_vl_q, b_dl_q, b_dr_q, b_hy_q, b_lx_q;
  logic signed [PW-1:0] b_lh_q, b_wlh_q, b_lvh_q, b_wlvh_q, b_wv_q, b_den_q;
  logic                 b_xl_q, b_xr_q;

  // Stage C: corner line
  logic                 c_v_q;
  ctpf_meta_t           c_meta_q;
  logic signed [SW-1:0] c_l_q, c_h_q;
  logic signed [PW-1:0] c_c_q, c_c1_q, c_den_q;
  logic                 c_sa_neg_q, c_sb_neg_q;
  logic                 m0, m1, m2, m3;
  logic signed [PW-1:0] yl1;
  corner_e              corner;
  logic                 any_corner;
  logic signed [PW-1:0] c_d, c1_d, hy_s, lx_s;
  logic                 sa_neg_d, sb_neg_d;
  ctpf_meta_t           c_meta_d;

  // Stage D: numerator products
  logic                 d_v_q;
  ctpf_meta_t           d_meta_q;
  logic signed [NW-1:0] d_hc_q, d_lc1_q, d_hc1_q, d_lc_q;
  logic signed [PW-1:0] d_den_q;
  logic                 d_sa_neg_q, d_sb_neg_q;
  logic signed [NW-1:0] nx, ny;

  assign xs = signed'(SW'(a_meta_q.x));
  assign ys = signed'(SW'(a_meta_q.y));
  assign ws = signed'(SW'(a_meta_q.w));
  assign vs = signed'(SW'(a_meta_q.v));
  assign ls = signed'(SW'(a_l_q));
  assign hs = signed'(SW'(a_h_q));

  // Tag the incoming item with the image size it is checked against
  always_comb begin
    a_meta_in   = meta_i;
    a_meta_in.w = cfg_i.w;
    a_meta_in.v = cfg_i.v;
  end

  // Flag positions outside the configured image
  always_comb begin
    a_meta_d     = a_meta_q;
    a_meta_d.oob = (xs >= ws) || (ys >= vs);
  end

  // Membership tests and corner choice, later corner wins
  assign yl1 = b_yl_q + PW'(b_l_q);
  assign m0  = b_xl_q && (b_yl_q <= b_dl_q);
  assign m1  = b_xr_q && (b_yl_q <= b_dr_q);
  assign m2  = b_xl_q && (yl1 > (b_vl_q - b_dl_q));
  assign m3  = b_xr_q && (yl1 > (b_vl_q - b_dr_q));
  assign any_corner = m0 || m1 || m2 || m3;

  always_comb begin
    if (m3) begin
      corner = CORNER_LR;
    end else if (m2) begin
      corner = CORNER_LL;
    end else if (m1) begin
      corner = CORNER_UR;
    end else begin
      corner = CORNER_UL;
    end
  end

  always_comb begin
    c_meta_d           = b_meta_q;
    c_meta_d.in_corner = any_corner && !b_meta_q.oob;
    sa_neg_d           = 1'b0;
    sb_neg_d           = 1'b0;
    unique case (corner)
      CORNER_UL: begin
        c_d = -b_lh_q;
        c_meta_d.ceil_x = 1'b1;
        c_meta_d.ceil_y = 1'b1;
      end
      CORNER_UR: begin
        c_d = -b_wlh_q;
        sb_neg_d = 1'b1;
        c_meta_d.ceil_x = 1'b0;
        c_meta_d.ceil_y = 1'b1;
      end
      CORNER_LL: begin
        c_d = -b_lvh_q;
        sa_neg_d = 1'b1;
        c_meta_d.ceil_x = 1'b1;
        c_meta_d.ceil_y = 1'b0;
      end
      default: begin
        c_d = b_wlvh_q - b_wv_q;
        c_meta_d.ceil_x = 1'b0;
        c_meta_d.ceil_y = 1'b0;
      end
    endcase
    hy_s = sa_neg_d ? -b_hy_q : b_hy_q;
    lx_s = sb_neg_d ? -b_lx_q : b_lx_q;
    c1_d = hy_s - lx_s;
  end

  // Combine the products into the projection numerators
  always_comb begin
    nx = (d_sa_neg_q ? d_hc_q : -d_hc_q) + (d_sb_neg_q ? d_lc1_q : -d_lc1_q);
    ny = (d_sa_neg_q ? -d_hc1_q : d_hc1_q) + (d_sb_neg_q ? d_lc_q : -d_lc_q);
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    a_meta_q   <= a_meta_in;
    a_l_q      <= cfg_i.l;
    a_h_q      <= cfg_i.h;

    b_meta_q <= a_meta_d;
    b_l_q    <= ls;
    b_h_q    <= hs;
    b_yl_q   <= ys * ls;
    b_vl_q   <= vs * ls;
    b_dl_q   <= (ls - xs) * hs;
    b_dr_q   <= (xs - ws + ls) * hs;
    b_hy_q   <= hs * ys;
    b_lx_q   <= ls * xs;
    b_lh_q   <= ls * hs;
    b_wlh_q  <= (ws - ls) * hs;
    b_lvh_q  <= ls * (vs - hs);
    b_wlvh_q <= (ws - ls) * (vs - hs);
    b_wv_q   <= ws * vs;
    b_den_q  <= hs * hs + ls * ls;
    b_xl_q   <= xs < ls;
    b_xr_q   <= xs >= (ws - ls);

    c_meta_q   <= c_meta_d;
    c_l_q      <= b_l_q;
    c_h_q      <= b_h_q;
    c_c_q      <= c_d;
    c_c1_q     <= c1_d;
    c_den_q    <= b_den_q;
    c_sa_neg_q <= sa_neg_d;
    c_sb_neg_q <= sb_neg_d;

    d_meta_q   <= c_meta_q;
    d_hc_q     <= c_h_q * c_c_q;
    d_lc1_q    <= c_l_q * c_c1_q;
    d_hc1_q    <= c_h_q * c_c1_q;
    d_lc_q     <= c_l_q * c_c_q;
    d_den_q    <= c_den_q;
    d_sa_neg_q <= c_sa_neg_q;
    d_sb_neg_q <= c_sb_neg_q;
  end

  assign valid_o = d_v_q;
  assign meta_o  = d_meta_q;
  assign neg_x_o = nx[NW-1];
  assign neg_y_o = ny[NW-1];
  assign mag_x_o = nx[NW-1] ? MagW'(-nx) : MagW'(nx);
  assign mag_y_o = ny[NW-1] ? MagW'(-ny) : MagW'(ny);
  assign den_o   = d_den_q[DenW-1:0];

endmodule

[sv/ctpf_div.sv]
// Pipelined restoring divider for both projection coordinates, one bit a stage.
module ctpf_div import ctpf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ctpf_meta_t       meta_i,
  input  logic             neg_x_i,
  input  logic             neg_y_i,
  input  logic [MagW-1:0]  mag_x_i,
  input  logic [MagW-1:0]  mag_y_i,
  input  logic [DenW-1:0]  den_i,
  output logic             valid_o,
  output ctpf_meta_t       meta_o,
  output logic             neg_x_o,
  output logic             neg_y_o,
  output logic [QW-1:0]    quo_x_o,
  output logic [QW-1:0]    quo_y_o,
  output logic             rem_x_nz_o,
  output logic             rem_y_nz_o
);

  logic             v_q     [QW+1];
  ctpf_meta_t       meta_q  [QW+1];
  logic             negx_q  [QW+1];
  logic             negy_q  [QW+1];
  logic [MagW-1:0]  rx_q    [QW+1];
  logic [MagW-1:0]  ry_q    [QW+1];
  logic [QW-1:0]    qx_q    [QW+1];
  logic [QW-1:0]    qy_q    [QW+1];
  logic [DenW-1:0]  den_q   [QW+1];

  // Capture the operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_i;
    negx_q[0] <= neg_x_i;
    negy_q[0] <= neg_y_i;
    rx_q[0]   <= mag_x_i;
    ry_q[0]   <= mag_y_i;
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
    den_q[0]  <= den_i;
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [MagW-1:0] dsh;
    logic            gex, gey;

    assign dsh = MagW'(den_q[j-1]) << (QW - j);
    assign gex = rx_q[j-1] >= dsh;
    assign gey = ry_q[j-1] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      meta_q[j] <= meta_q[j-1];
      negx_q[j] <= negx_q[j-1];
      negy_q[j] <= negy_q[j-1];
      den_q[j]  <= den_q[j-1];
      rx_q[j]   <= gex ? (rx_q[j-1] - dsh) : rx_q[j-1];
      ry_q[j]   <= gey ? (ry_q[j-1] - dsh) : ry_q[j-1];
      qx_q[j]   <= qx_q[j-1] | (QW'(gex) << (QW - j));
      qy_q[j]   <= qy_q[j-1] | (QW'(gey) << (QW - j));
    end
  end

  assign valid_o    = v_q[QW];
  assign meta_o     = meta_q[QW];
  assign neg_x_o    = negx_q[QW];
  assign neg_y_o    = negy_q[QW];
  assign quo_x_o    = qx_q[QW];
  assign quo_y_o    = qy_q[QW];
  assign rem_x_nz_o = |rx_q[QW];
  assign rem_y_nz_o = |ry_q[QW];

endmodule

[sv/corner_triangle_projection_fill.sv]
// Top level of the corner triangle fill frame store.
//
// Commands enter one per clock: busy is never raised, so a start is taken in
// every cycle. A write stores its pixel and gives no result; a read gives one
// result on done_o after its start has passed four geometry stages, the
// divider's operand stage and eleven quotient stages for the exact projection,
// and the registered read of the frame memory. Writes and reads reach the
// frame memory in command order at the same stage, so a read always sees every
// earlier write. The receiver cannot stall the results.
// Configuration must only be written while no read is in flight.
module corner_triangle_projection_fill import ctpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              command_i,
  input  logic [XW-1:0]     pos_x_i,
  input  logic [YW-1:0]     pos_y_i,
  input  logic [PixW-1:0]   pixel_in_i,
  output logic              done_o,
  output logic [PixW-1:0]   pixel_out_o,
  output logic              in_corner_o,
  output logic              source_outside_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [DimW-1:0] width_q, height_q;
  logic [LegW-1:0] clen_q, cheight_q;
  reg_e            reg_sel;
  ctpf_cfg_t       cfg;
  ctpf_meta_t      in_meta;

  logic            g_valid;
  ctpf_meta_t      g_meta;
  logic            g_negx, g_negy;
  logic [MagW-1:0] g_magx, g_magy;
  logic [DenW-1:0] g_den;

  logic            q_valid;
  ctpf_meta_t      q_meta;
  logic            q_negx, q_negy;
  logic [QW-1:0]   q_x, q_y;
  logic            q_rx_nz, q_ry_nz;

  logic [QW:0]     mag_x, mag_y;
  logic            out_x, out_y, src_out;
  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [PixW-1:0] ram_rdata;

  logic            f_valid_q;
  logic            f_zero_q, f_corner_q, f_src_q;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DimW'(MaxWidth);
      height_q  <= DimW'(MaxHeight);
      clen_q    <= '0;
      cheight_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_WIDTH:   width_q   <= pwdata[DimW-1:0];
        REG_HEIGHT:  height_q  <= pwdata[DimW-1:0];
        REG_CLEN:    clen_q    <= pwdata[LegW-1:0];
        REG_CHEIGHT: cheight_q <= pwdata[LegW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:   prdata = 32'(width_q);
      REG_HEIGHT:  prdata = 32'(height_q);
      REG_CLEN:    prdata = 32'(clen_q);
      REG_CHEIGHT: prdata = 32'(cheight_q);
      default:     prdata = '0;
    endcase
  end

  // Saturate the image size and widen the corner legs
  always_comb begin
    cfg.w = (width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
    cfg.v = (height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
    cfg.l = DimW'(clen_q) + DimW'(CornerExtra);
    cfg.h = DimW'(cheight_q) + DimW'(CornerExtra);
  end

  always_comb begin
    in_meta           = '0;
    in_meta.cmd       = cmd_e'(command_i);
    in_meta.x         = pos_x_i;
    in_meta.y         = pos_y_i;
    in_meta.pix       = pixel_in_i;
  end

  ctpf_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .meta_i  (in_meta),
    .cfg_i   (cfg),
    .valid_o (g_valid),
    .meta_o  (g_meta),
    .neg_x_o (g_negx),
    .neg_y_o (g_negy),
    .mag_x_o (g_magx),
    .mag_y_o (g_magy),
    .den_o   (g_den)
  );

  ctpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (g_valid),
    .meta_i     (g_meta),
    .neg_x_i    (g_negx),
    .neg_y_i    (g_negy),
    .mag_x_i    (g_magx),
    .mag_y_i    (g_magy),
    .den_i      (g_den),
    .valid_o    (q_valid),
    .meta_o     (q_meta),
    .neg_x_o    (q_negx),
    .neg_y_o    (q_negy),
    .quo_x_o    (q_x),
    .quo_y_o    (q_y),
    .rem_x_nz_o (q_rx_nz),
    .rem_y_nz_o (q_ry_nz)
  );

  // Round each quotient by its corner's rule and check the source lies inside
  always_comb begin
    mag_x = (QW+1)'(q_x) + (QW+1)'(q_rx_nz && (q_negx ^ q_meta.ceil_x));
    mag_y = (QW+1)'(q_y) + (QW+1)'(q_ry_nz && (q_negy ^ q_meta.ceil_y));
    out_x = q_negx ? (mag_x != '0) : (mag_x >= (QW+1)'(q_meta.w));
    out_y = q_negy ? (mag_y != '0) : (mag_y >= (QW+1)'(q_meta.v));
    src_out = q_meta.in_corner && (out_x || out_y);
  end

  // Address the frame: projected source for corner reads, else the position itself
  assign ram_we   = q_valid && (q_meta.cmd == CMD_WRITE);
  assign ram_addr = (q_meta.in_corner && (q_meta.cmd == CMD_READ))
                  ? {mag_y[YW-1:0], mag_x[XW-1:0]}
                  : {q_meta.y, q_meta.x};

  ctpf_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (q_meta.pix),
    .rdata_o (ram_rdata)
  );

  // Hold the result flags beside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= q_valid && (q_meta.cmd == CMD_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    f_zero_q   <= q_meta.oob || src_out;
    f_corner_q <= q_meta.in_corner;
    f_src_q    <= src_out;
  end

  assign done_o           = f_valid_q;
  assign pixel_out_o      = f_zero_q ? '0 : ram_rdata;
  assign in_corner_o      = f_corner_q;
  assign source_outside_o = f_src_q;

endmodule

[bench/tb_corner_triangle_projection_fill.sv]
// Self-checking testbench of the corner triangle fill frame store.
module tb_corner_triangle_projection_fill;
  import ctpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 30;
  localparam longint CycleLimit = 2000000;

  typedef struct {
    logic [PixW-1:0] pix;
    logic            in_corner;
    logic            src_out;
  } fill_result_t;

  typedef struct {
    int              geom;
    cmd_e            cmd;
    logic [XW-1:0]   x;
    logic [YW-1:0]   y;
    logic [PixW-1:0] pix;
    bit              typed;
    fill_result_t    res;
  } table_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              command_i;
  logic [XW-1:0]     pos_x_i;
  logic [YW-1:0]     pos_y_i;
  logic [PixW-1:0]   pixel_in_i;
  logic              done_o;
  logic [PixW-1:0]   pixel_out_o;
  logic              in_corner_o;
  logic              source_outside_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow of the frame and geometry registers
  logic [PixW-1:0] frame_shadow [Depth];
  bit              written [Depth];
  logic [DimW-1:0] geo_w, geo_v;
  logic [LegW-1:0] geo_clen, geo_chgt;

  fill_result_t pending_reads[$];
  int           errors;
  longint       cycles;
  int           idle_pct;

  corner_triangle_projection_fill i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Count cycles and abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [PixW-1:0] got,
                                 input logic [PixW-1:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Check each read result against the oldest expectation
  always @(posedge clk_i) begin
    fill_result_t e;
    if (rst_ni && done_o) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected result", pixel_out_o, '0);
      end else begin
        e = pending_reads.pop_front();
        if (pixel_out_o !== e.pix) report_mismatch("pixel_out", pixel_out_o, e.pix);
        if (in_corner_o !== e.in_corner)
          report_mismatch("in_corner", in_corner_o, e.in_corner);
        if (source_outside_o !== e.src_out)
          report_mismatch("source_outside", source_outside_o, e.src_out);
      end
    end
  end

  function automatic longint div_round(longint n, longint d, bit up);
    longint q;
    q = n / d;
    if ((n % d) != 0) begin
      if (up && n > 0) q++;
      if (!up && n < 0) q--;
    end
    return q;
  endfunction

  // Work out the corner-filled pixel at (px,py) and the frame entry it reads
  function automatic fill_result_t fill_pixel(longint px, longint py, output longint addr);
    fill_result_t r;
    longint w, v, l, h, ax, ay, bx, by, a, b, c, c1, den, sx, sy;
    bit hit, cx, cy;
    addr = -1;
    r = '{'0, 1'b0, 1'b0};
    w = (geo_w > MaxWidth) ? MaxWidth : geo_w;
    v = (geo_v > MaxHeight) ? MaxHeight : geo_v;
    l = geo_clen + CornerExtra;
    h = geo_chgt + CornerExtra;
    hit = 0;
    if (px >= w || py >= v) return r;
    if (px < l && py * l <= (l - px) * h) begin
      hit = 1; ax = 0; ay = h; bx = l; by = 0; cx = 1; cy = 1;
    end
    if (px >= w - l && py * l <= (px - w + l) * h) begin
      hit = 1; ax = w; ay = h; bx = w - l; by = 0; cx = 0; cy = 1;
    end
    if (px < l && (py + 1) * l > v * l - (l - px) * h) begin
      hit = 1; ax = 0; ay = v - h; bx = l; by = v; cx = 1; cy = 0;
    end
    if (px >= w - l && (py + 1) * l > v * l - (px - w + l) * h) begin
      hit = 1; ax = w - l; ay = v; bx = w; by = v - h; cx = 0; cy = 0;
    end
    if (!hit) begin
      addr = py * MaxWidth + px;
      r.pix = frame_shadow[addr];
      return r;
    end
    a = ay - by;
    b = bx - ax;
    c = ax * by - bx * ay;
    c1 = a * py - b * px;
    den = a * a + b * b;
    sx = div_round(-a * c - b * c1, den, cx);
    sy = div_round(a * c1 - b * c, den, cy);
    r.in_corner = 1'b1;
    if (sx < 0 || sy < 0 || sx >= w || sy >= v) begin
      r.src_out = 1'b1;
    end else begin
      addr = sy * MaxWidth + sx;
      r.pix = frame_shadow[addr];
    end
    return r;
  endfunction

  task automatic reg_write(input reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = PaddrW'({idx, 2'b00}); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_geometry(input int w, input int v, input int cl, input int ch);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, v);
    reg_write(REG_CLEN, cl);
    reg_write(REG_CHEIGHT, ch);
    geo_w = w; geo_v = v; geo_clen = cl; geo_chgt = ch;
  endtask

  // Drop start and let every read in flight come out
  task automatic drain;
    @(negedge clk_i);
    start = 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer one item, idling at random, and record what it should give
  task automatic offer_item(input cmd_e cmd, input logic [XW-1:0] x,
                            input logic [YW-1:0] y, input logic [PixW-1:0] pix,
                            input bit typed, input fill_result_t res);
    longint addr;
    fill_result_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1; command_i = cmd; pos_x_i = x; pos_y_i = y; pixel_in_i = pix;
    do @(posedge clk_i); while (busy);
    if (cmd == CMD_WRITE) begin
      frame_shadow[y * MaxWidth + x] = pix;
      written[y * MaxWidth + x] = 1'b1;
    end else begin
      want = fill_pixel(x, y, addr);
      pending_reads.push_back(typed ? res : want);
    end
  endtask

  // Write any frame entry a read would touch before it holds data, then send the item
  task automatic send_item(input cmd_e cmd, input logic [XW-1:0] x,
                           input logic [YW-1:0] y, input logic [PixW-1:0] pix,
                           input bit typed, input fill_result_t res);
    longint addr;
    fill_result_t none;
    none = '{'0, 1'b0, 1'b0};
    if (cmd == CMD_READ) begin
      void'(fill_pixel(x, y, addr));
      if (addr >= 0 && !written[addr])
        offer_item(CMD_WRITE, addr[XW-1:0], addr[AddrW-1:XW], $urandom, 0, none);
    end
    offer_item(cmd, x, y, pix, typed, res);
  endtask

  // One random phase: set the geometry, send n random items, then drain
  task automatic random_phase(input int w, input int v, input int cl, input int ch,
                              input int n);
    int rx, ry;
    fill_result_t none;
    none = '{'0, 1'b0, 1'b0};
    set_geometry(w, v, cl, ch);
    for (int i = 0; i < n; i++) begin
      rx = (geo_w != 0 && $urandom_range(9) < 8) ? $urandom_range(geo_w - 1) : $urandom;
      ry = (geo_v != 0 && $urandom_range(9) < 8) ? $urandom_range(geo_v - 1) : $urandom;
      if (rx > 255) rx = $urandom_range(255);
      if (ry > 255) ry = $urandom_range(255);
      send_item($urandom_range(3) == 0 ? CMD_WRITE : CMD_READ, rx, ry, $urandom, 0, none);
    end
    drain();
  endtask

  table_row_t directed[$];

  initial begin
    errors = 0; cycles = 0; idle_pct = 0;
    rst_ni = 1'b0; start = 1'b0; command_i = CMD_WRITE;
    pos_x_i = '0; pos_y_i = '0; pixel_in_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: geometry set, item, and a typed answer where obvious
    directed = '{
      '{0, CMD_WRITE, 128, 128, 32'hFFFF_FFFF, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  128, 128, 0, 1, '{32'hFFFF_FFFF, 0, 0}},
      '{0, CMD_WRITE, 128, 128, 32'h0, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  128, 128, 0, 1, '{32'h0, 0, 0}},
      '{0, CMD_WRITE, 3, 3, 32'hA5A5_5A5A, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  0, 0, 0, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  255, 0, 0, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  0, 255, 0, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  255, 255, 0, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  4, 0, 0, 0, '{'0, 0, 0}},
      '{0, CMD_READ,  5, 0, 0, 0, '{'0, 0, 0}},
      '{1, CMD_READ,  255, 255, 0, 1, '{32'h0, 0, 0}},
      '{1, CMD_READ,  200, 50, 0, 1, '{32'h0, 0, 0}},
      '{1, CMD_READ,  10, 100, 0, 1, '{32'h0, 0, 0}},
      '{1, CMD_READ,  199, 99, 0, 0, '{'0, 0, 0}},
      '{1, CMD_READ,  0, 99, 0, 0, '{'0, 0, 0}},
      '{1, CMD_READ,  0, 0, 0, 0, '{'0, 0, 0}},
      '{1, CMD_READ,  199, 0, 0, 0, '{'0, 0, 0}},
      '{1, CMD_READ,  10, 2, 0, 0, '{'0, 0, 0}},
      '{1, CMD_READ,  100, 50, 0, 0, '{'0, 0, 0}},
      '{2, CMD_READ,  0, 0, 0, 1, '{32'h0, 0, 0}},
      '{2, CMD_READ,  2, 0, 0, 0, '{'0, 0, 0}},
      '{2, CMD_READ,  0, 2, 0, 0, '{'0, 0, 0}}
    };
    foreach (directed[i]) begin
      if (i == 0 || directed[i].geom != directed[i-1].geom) begin
        if (i != 0) drain();
        case (directed[i].geom)
          0: set_geometry(256, 256, 0, 0);
          1: set_geometry(200, 100, 20, 0);
          default: set_geometry(0, 3, 251, 251);
        endcase
      end
      send_item(directed[i].cmd, directed[i].x, directed[i].y, directed[i].pix,
                directed[i].typed, directed[i].res);
    end
    drain();

    // Random phases: light sender gaps, heavy gaps, then none
    idle_pct = 8;
    random_phase(511, 511, 251, 251, 120);
    random_phase(256, 256, 0, 0, 120);
    idle_pct = 65;
    random_phase(37, 19, 0, 251, 120);
    random_phase(1, 256, 251, 0, 120);
    idle_pct = 0;
    random_phase($urandom_range(1, 256), $urandom_range(1, 256),
                 $urandom_range(0, 251), $urandom_range(0, 251), 120);
    random_phase($urandom_range(511), $urandom_range(511),
                 $urandom_range(255), $urandom_range(255), 120);

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
